FILE: design/sipow_pkg.sv
// ============================================================================
// sipow_pkg
// Shared types and constants for the checked signed 64-bit integer power.
// ============================================================================
package sipow_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = WORD_W / 2;
    localparam int unsigned PROD_W = 2 * WORD_W;

    // status codes of a result word
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NEG_EXP = 2'd1;
    localparam logic [1:0] STATUS_OVF     = 2'd2;

    // magnitude of the most negative 64-bit value
    localparam logic [WORD_W-1:0] MIN_MAG = {1'b1, {(WORD_W-1){1'b0}}};

    // multiplier sequencing: four partial products, then the last one accumulated and one finishing step
    localparam logic [2:0] MUL_STEP_LAST_PP = 3'd3;
    localparam logic [2:0] MUL_STEP_FINISH  = 3'd5;

    // partial product weight codes, in units of HALF_W bits
    localparam logic [1:0] PP_SH_0 = 2'd0;
    localparam logic [1:0] PP_SH_1 = 2'd1;
    localparam logic [1:0] PP_SH_2 = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_SHIFT,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef enum logic {
        DEST_ACC,
        DEST_SQ
    } dest_t;

    // two's complement magnitude, exact for the most negative value
    function automatic logic [WORD_W-1:0] mag_of(input logic [WORD_W-1:0] x);
        mag_of = x[WORD_W-1] ? (~x + WORD_W'(1)) : x;
    endfunction

endpackage

FILE: design/signed_int_power_overflow_check.sv
// ============================================================================
// signed_int_power_overflow_check
// Signed 64-bit base raised to a signed 64-bit exponent by right-to-left
// square-and-multiply, every multiply checked for signed 64-bit overflow.
// ============================================================================
// Sequencing: a negative exponent goes straight to the output state; otherwise
//   the exponent is scanned bit by bit, and each checked multiply uses one
//   32x32 multiplier, four partial products and a finishing check.
//   Overflow ends the word early.
// Throughput: one word at a time; s_ready is high only while idle.
// Reset: aresetn synchronous, active low; returns to idle with no word held.
module signed_int_power_overflow_check
    import sipow_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [WORD_W-1:0] s_base,
    input  logic signed [WORD_W-1:0] s_exponent,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_power_value,
    output logic [1:0]               m_status
);

    state_t state_reg, state_next;

    logic [WORD_W-1:0]   acc_reg;
    logic [WORD_W-1:0]   sq_reg;
    logic [WORD_W-2:0]   e_reg;
    logic [2:0]          step_reg;
    dest_t               dest_reg;
    logic                neg_reg;
    logic [WORD_W-1:0]   mag_a_reg;
    logic [WORD_W-1:0]   mag_b_reg;
    logic [WORD_W-1:0]   pp_reg;
    logic [1:0]          pp_sh_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [WORD_W-1:0]   power_value_reg;
    logic [1:0]          status_reg;

    logic [HALF_W-1:0]   a_part;
    logic [HALF_W-1:0]   b_part;
    logic [WORD_W-1:0]   pp_prod;
    logic [1:0]          pp_sh_next;
    logic [PROD_W-1:0]   pp_shifted;
    logic [WORD_W-1:0]   op_x;
    logic                prod_hi_zero;
    logic                prod_fits;
    logic [WORD_W-1:0]   mul_result;
    logic                mul_done;

    // partial product operand select: step bit 1 picks a half, bit 0 b half
    assign a_part  = step_reg[1] ? mag_a_reg[WORD_W-1:HALF_W] : mag_a_reg[HALF_W-1:0];
    assign b_part  = step_reg[0] ? mag_b_reg[WORD_W-1:HALF_W] : mag_b_reg[HALF_W-1:0];
    assign pp_prod = a_part * b_part;

    // weight of the partial product issued this step
    always_comb begin
        unique case (step_reg[1:0])
            2'd0:    pp_sh_next = PP_SH_0;
            2'd3:    pp_sh_next = PP_SH_2;
            default: pp_sh_next = PP_SH_1;
        endcase
    end

    // align the registered partial product
    always_comb begin
        unique case (pp_sh_reg)
            PP_SH_0: pp_shifted = {{WORD_W{1'b0}}, pp_reg};
            PP_SH_1: pp_shifted = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            PP_SH_2: pp_shifted = {pp_reg, {WORD_W{1'b0}}};
            default: pp_shifted = '0;
        endcase
    end

    // overflow check and signed result of the finished magnitude product
    assign prod_hi_zero = (prod_reg[PROD_W-1:WORD_W] == '0);
    assign prod_fits    = (prod_hi_zero && !prod_reg[WORD_W-1])
                       || (neg_reg && prod_hi_zero && prod_reg[WORD_W-1:0] == MIN_MAG);
    assign mul_result   = neg_reg ? (~prod_reg[WORD_W-1:0] + WORD_W'(1))
                                  : prod_reg[WORD_W-1:0];
    assign mul_done     = (state_reg == ST_MUL) && (step_reg == MUL_STEP_FINISH);

    // first multiply operand: running result on a set bit, square otherwise
    assign op_x = (state_reg == ST_BIT) ? acc_reg : sq_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_exponent[WORD_W-1] ? ST_OUT : ST_BIT;
                end
            end
            ST_BIT: begin
                if (e_reg == '0) begin
                    state_next = ST_OUT;
                end else if (e_reg[0]) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                state_next = (e_reg[WORD_W-2:1] == '0) ? ST_OUT : ST_MUL;
            end
            ST_MUL: begin
                if (step_reg == MUL_STEP_FINISH) begin
                    if (!prod_fits) begin
                        state_next = ST_OUT;
                    end else if (dest_reg == DEST_ACC) begin
                        state_next = ST_SHIFT;
                    end else begin
                        state_next = ST_BIT;
                    end
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_OUT);
    end

    assign m_power_value = power_value_reg;
    assign m_status      = status_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_MUL && step_reg != MUL_STEP_FINISH) begin
                step_reg <= step_reg + 3'd1;
            end else begin
                step_reg <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                acc_reg <= WORD_W'(1);
                sq_reg  <= s_base;
                e_reg   <= s_exponent[WORD_W-2:0];
                if (s_exponent[WORD_W-1]) begin
                    power_value_reg <= '0;
                    status_reg      <= STATUS_NEG_EXP;
                end
            end
            ST_BIT, ST_SHIFT: begin
                // load operands for the next checked multiply
                mag_a_reg <= mag_of(op_x);
                mag_b_reg <= mag_of(sq_reg);
                neg_reg   <= op_x[WORD_W-1] ^ sq_reg[WORD_W-1];
                dest_reg  <= (state_reg == ST_BIT) ? DEST_ACC : DEST_SQ;
                if (state_reg == ST_SHIFT) begin
                    e_reg <= e_reg >> 1;
                end
                if ((state_reg == ST_BIT && e_reg == '0)
                    || (state_reg == ST_SHIFT && e_reg[WORD_W-2:1] == '0)) begin
                    power_value_reg <= acc_reg;
                    status_reg      <= STATUS_OK;
                end
            end
            ST_MUL: begin
                // issue partial products, accumulate the previous one
                if (step_reg <= MUL_STEP_LAST_PP) begin
                    pp_reg    <= pp_prod;
                    pp_sh_reg <= pp_sh_next;
                end
                if (step_reg == '0) begin
                    prod_reg <= '0;
                end else if (!mul_done) begin
                    prod_reg <= prod_reg + pp_shifted;
                end
                if (mul_done) begin
                    if (!prod_fits) begin
                        power_value_reg <= '0;
                        status_reg      <= STATUS_OVF;
                    end else if (dest_reg == DEST_ACC) begin
                        acc_reg <= mul_result;
                    end else begin
                        sq_reg <= mul_result;
                    end
                end
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output sides active together");

    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_OVF) |-> (m_power_value == '0))
        else $error("overflow word carries a nonzero value");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK || m_status == STATUS_NEG_EXP
                     || m_status == STATUS_OVF))
        else $error("undefined status code");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (step_reg <= MUL_STEP_FINISH))
        else $error("multiply step counter out of range");

    a_neg_exp_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_exponent[WORD_W-1])
            |=> (m_valid && m_status == STATUS_NEG_EXP))
        else $error("negative exponent not flagged on the next cycle");

endmodule
